// File: hw/rtl/ohlc_pkg.sv
// ohlc_pkg: field layout, calendar constants and small tables for the hourly bar builder
`timescale 1ns / 1ps

package ohlc_pkg;

   // field widths
   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 7;
   localparam int DAY_W     = 7;
   localparam int HOUR_W    = 7;
   localparam int PRICE_W   = 32;
   localparam int START_W   = 38;
   localparam int MID_OUT_W = 33;

   // beat layout, lowest bit first
   localparam int YEAR_LSB   = 0;
   localparam int MONTH_LSB  = YEAR_LSB + YEAR_W;
   localparam int DAY_LSB    = MONTH_LSB + MONTH_W;
   localparam int HOUR_LSB   = DAY_LSB + DAY_W;
   localparam int BID_LSB    = HOUR_LSB + HOUR_W;
   localparam int ASK_LSB    = BID_LSB + PRICE_W;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_USED_W = START_W + 4 * MID_OUT_W;
   localparam int RSP_DATA_W = 176;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   // command codes carried on tuser
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // internal date widths
   localparam int ERA_W  = 5;
   localparam int YOE_W  = 9;
   localparam int DOY_W  = 9;
   localparam int HR_W   = 5;
   localparam int DAYS_W = 22;
   localparam int CENT_W = 3;

   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [DAYS_W-1:0]  days_type;
   typedef logic [START_W-1:0] start_type;

   // validity limits
   localparam logic [YEAR_W-1:0]  MIN_YEAR  = 14'd2000;
   localparam logic [MONTH_W-1:0] MAX_MONTH = 7'd12;
   localparam logic [DAY_W-1:0]   MAX_DAY   = 7'd31;
   localparam logic [HOUR_W-1:0]  MAX_HOUR  = 7'd23;

   // y / 400 as (y * 5243) >> 21, exact for 14-bit y
   localparam logic [12:0] ERA_RECIP  = 13'd5243;
   localparam int          ERA_SHIFT  = 21;
   // yoe / 100 as (yoe * 41) >> 12, exact for yoe < 400
   localparam logic [5:0]  CENT_RECIP = 6'd41;
   localparam int          CENT_SHIFT = 12;

   localparam logic [YEAR_W-1:0] YEARS_PER_ERA = 14'd400;
   localparam days_type DAYS_PER_ERA  = 22'd146097;
   localparam days_type DAYS_PER_YEAR = 22'd365;
   localparam days_type EPOCH_OFFSET  = 22'd719468;
   localparam logic [16:0] DAY_SECONDS  = 17'd86400;
   localparam logic [11:0] HOUR_SECONDS = 12'd3600;

   // days before a month, months counted from march
   function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] mshift);
      logic [DOY_W-1:0] d;
      case (mshift)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// File: hw/rtl/tick_to_hourly_ohlc_bars_top.sv
// tick_to_hourly_ohlc_bars_top: hourly open/high/low/close bar builder over parsed quote ticks
`timescale 1ns / 1ps

// Quote ticks arrive on the req stream: tdata carries year, month, day, hour, bid and
// ask, tuser says whether the beat is a tick or an end of stream flush. Invalid ticks
// (year below 2000, month, day or hour out of range, a zero price) are dropped.
// The block keeps one open bar keyed by the epoch second of its hour start. A valid
// tick in the same hour updates high, low and close; a tick in another hour sends the
// held bar out on the rsp stream and opens a new one. A flush sends the held bar and
// leaves no bar open. Each rsp beat carries start, open, high, low and close.
// Throughput is one beat per cycle unless a bar-closing beat waits on a stalled rsp:
// five register stages (input, era split, year of era, day count, hour key) feed the
// bar update, which reads and writes the held bar in the same cycle, so back to back
// ticks of the same hour need no stall; the closed bar then goes to the output register.
// When rsp is stalled with a beat waiting, ticks that emit nothing still pass;
// the next bar-closing beat waits in the last stage and backs up the pipe.
// Reset clears all stage valids, the output valid and the open-bar flag.
module tick_to_hourly_ohlc_bars_top
   import ohlc_pkg::*;
#(
   parameter int PRICE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // year, month, day, hour, bid, ask
   input  logic                  req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // bar_start, open, high, low, close
);

   localparam int USED_BITS = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
   localparam int MID_W     = USED_BITS + 1;

   // stage 1: input register
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_cmd_ff;
   year_type             s1_year_ff;
   logic [MONTH_W-1:0]   s1_month_ff;
   logic [DAY_W-1:0]     s1_day_ff;
   logic [HOUR_W-1:0]    s1_hour_ff;
   logic [USED_BITS-1:0] s1_bid_ff, s1_ask_ff;

   // stage 2: era split
   logic                 s2_vld_ff, s2_vld_in;
   logic                 s2_cmd_ff, s2_ok_ff, s2_ok_in;
   logic [MID_W-1:0]     s2_mid_ff, s2_mid_in;
   year_type             s2_y_ff, s2_y_in;
   logic [ERA_W-1:0]     s2_era_ff, s2_era_in;
   logic [DOY_W-1:0]     s2_doy_ff, s2_doy_in;
   logic [HR_W-1:0]      s2_hour_ff;

   // stage 3: year of era
   logic                 s3_vld_ff, s3_vld_in;
   logic                 s3_cmd_ff, s3_ok_ff;
   logic [MID_W-1:0]     s3_mid_ff;
   logic [ERA_W-1:0]     s3_era_ff;
   logic [YOE_W-1:0]     s3_yoe_ff, s3_yoe_in;
   logic [DOY_W-1:0]     s3_doy_ff;
   logic [HR_W-1:0]      s3_hour_ff;

   // stage 4: day count
   logic                 s4_vld_ff, s4_vld_in;
   logic                 s4_cmd_ff, s4_ok_ff;
   logic [MID_W-1:0]     s4_mid_ff;
   days_type             s4_days_ff, s4_days_in;
   logic [HR_W-1:0]      s4_hour_ff;

   // stage 5: hour key
   logic                 s5_vld_ff, s5_vld_in;
   logic                 s5_cmd_ff, s5_ok_ff;
   logic [MID_W-1:0]     s5_mid_ff;
   start_type            s5_key_ff, s5_key_in;

   // held bar
   logic                 open_ff, open_in;
   start_type            held_start_ff, held_start_in;
   logic [MID_W-1:0]     held_open_ff, held_open_in;
   logic [MID_W-1:0]     held_high_ff, held_high_in;
   logic [MID_W-1:0]     held_low_ff, held_low_in;
   logic [MID_W-1:0]     held_close_ff, held_close_in;

   // output register
   logic                 rsp_vld_ff, rsp_vld_in;
   start_type            rsp_start_ff;
   logic [MID_W-1:0]     rsp_open_ff, rsp_high_ff, rsp_low_ff, rsp_close_ff;

   // flow control
   logic req_acc, ld2, ld3, ld4, ld5;
   logic rdy2, rdy3, rdy4, rdy5;
   logic p_emit, p_go, p_new, out_free;

   // intermediate arithmetic
   logic [YEAR_W+12:0]   era_prod;
   logic [MONTH_W-1:0]   mshift;
   year_type             yoe_full;
   logic [YOE_W+5:0]     cent_prod;
   logic [CENT_W-1:0]    cent;

   // ---------------------------------------------------------------- handshake
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign p_new      = s5_key_ff != held_start_ff;
   assign p_emit     = open_ff && ((s5_cmd_ff == CMD_FLUSH) || (s5_ok_ff && p_new));
   assign p_go       = s5_vld_ff && (!p_emit || out_free);

   assign rdy5       = !s5_vld_ff || p_go;
   assign rdy4       = !s4_vld_ff || rdy5;
   assign rdy3       = !s3_vld_ff || rdy4;
   assign rdy2       = !s2_vld_ff || rdy3;
   assign req_tready = !s1_vld_ff || rdy2;
   assign req_acc    = req_tvalid && req_tready;
   assign ld2        = s1_vld_ff && rdy2;
   assign ld3        = s2_vld_ff && rdy3;
   assign ld4        = s3_vld_ff && rdy4;
   assign ld5        = s4_vld_ff && rdy5;

   always_comb begin
      s1_vld_in  = req_acc ? 1'b1 : (rdy2 ? 1'b0 : s1_vld_ff);
      s2_vld_in  = ld2 ? 1'b1 : (rdy3 ? 1'b0 : s2_vld_ff);
      s3_vld_in  = ld3 ? 1'b1 : (rdy4 ? 1'b0 : s3_vld_ff);
      s4_vld_in  = ld4 ? 1'b1 : (rdy5 ? 1'b0 : s4_vld_ff);
      s5_vld_in  = ld5 ? 1'b1 : (p_go ? 1'b0 : s5_vld_ff);
      rsp_vld_in = (p_go && p_emit) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
   end

   // ---------------------------------------------------------------- stage 1 -> 2
   always_comb begin
      s2_y_in   = s1_year_ff - {{(YEAR_W-1){1'b0}}, (s1_month_ff <= 7'd2)};
      era_prod  = (YEAR_W+13)'(s2_y_in) * (YEAR_W+13)'(ERA_RECIP);
      s2_era_in = era_prod[ERA_SHIFT +: ERA_W];
      // months counted from march so the leap day falls at the end of the year
      mshift    = (s1_month_ff > 7'd2) ? (s1_month_ff - 7'd3) : (s1_month_ff + 7'd9);
      s2_doy_in = days_before_month(mshift[3:0]) + DOY_W'(s1_day_ff) - 9'd1;
      s2_mid_in = {1'b0, s1_bid_ff} + {1'b0, s1_ask_ff};
      s2_ok_in  = (s1_year_ff >= MIN_YEAR) &&
                  (s1_month_ff != 7'd0) && (s1_month_ff <= MAX_MONTH) &&
                  (s1_day_ff != 7'd0) && (s1_day_ff <= MAX_DAY) &&
                  (s1_hour_ff <= MAX_HOUR) &&
                  (s1_bid_ff != '0) && (s1_ask_ff != '0);
   end

   // ---------------------------------------------------------------- stage 2 -> 3
   always_comb begin
      yoe_full  = s2_y_ff - (YEAR_W'(s2_era_ff) * YEARS_PER_ERA);
      s3_yoe_in = yoe_full[YOE_W-1:0];
   end

   // ---------------------------------------------------------------- stage 3 -> 4
   always_comb begin
      cent_prod  = (YOE_W+6)'(s3_yoe_ff) * (YOE_W+6)'(CENT_RECIP);
      cent       = cent_prod[CENT_SHIFT +: CENT_W];
      s4_days_in = DAYS_W'(s3_era_ff) * DAYS_PER_ERA
                 + DAYS_W'(s3_yoe_ff) * DAYS_PER_YEAR
                 + DAYS_W'(s3_yoe_ff[YOE_W-1:2])
                 - DAYS_W'(cent)
                 + DAYS_W'(s3_doy_ff)
                 - EPOCH_OFFSET;
   end

   // ---------------------------------------------------------------- stage 4 -> 5
   assign s5_key_in = START_W'(s4_days_ff) * START_W'(DAY_SECONDS)
                    + START_W'(s4_hour_ff) * START_W'(HOUR_SECONDS);

   // ---------------------------------------------------------------- bar update
   always_comb begin
      open_in       = open_ff;
      held_start_in = held_start_ff;
      held_open_in  = held_open_ff;
      held_high_in  = held_high_ff;
      held_low_in   = held_low_ff;
      held_close_in = held_close_ff;
      if (p_go) begin
         if (s5_cmd_ff == CMD_FLUSH) begin
            open_in = 1'b0;
         end else if (s5_ok_ff) begin
            if (open_ff && !p_new) begin
               if (s5_mid_ff > held_high_ff) begin
                  held_high_in = s5_mid_ff;
               end
               if (s5_mid_ff < held_low_ff) begin
                  held_low_in = s5_mid_ff;
               end
               held_close_in = s5_mid_ff;
            end else begin
               open_in       = 1'b1;
               held_start_in = s5_key_ff;
               held_open_in  = s5_mid_ff;
               held_high_in  = s5_mid_ff;
               held_low_in   = s5_mid_ff;
               held_close_in = s5_mid_ff;
            end
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         open_ff    <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         s4_vld_ff  <= s4_vld_in;
         s5_vld_ff  <= s5_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         open_ff    <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff   <= req_tuser;
         s1_year_ff  <= req_tdata[YEAR_LSB +: YEAR_W];
         s1_month_ff <= req_tdata[MONTH_LSB +: MONTH_W];
         s1_day_ff   <= req_tdata[DAY_LSB +: DAY_W];
         s1_hour_ff  <= req_tdata[HOUR_LSB +: HOUR_W];
         s1_bid_ff   <= req_tdata[BID_LSB +: USED_BITS];
         s1_ask_ff   <= req_tdata[ASK_LSB +: USED_BITS];
      end
      if (ld2) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_ok_ff   <= s2_ok_in;
         s2_mid_ff  <= s2_mid_in;
         s2_y_ff    <= s2_y_in;
         s2_era_ff  <= s2_era_in;
         s2_doy_ff  <= s2_doy_in;
         s2_hour_ff <= s1_hour_ff[HR_W-1:0];
      end
      if (ld3) begin
         s3_cmd_ff  <= s2_cmd_ff;
         s3_ok_ff   <= s2_ok_ff;
         s3_mid_ff  <= s2_mid_ff;
         s3_era_ff  <= s2_era_ff;
         s3_yoe_ff  <= s3_yoe_in;
         s3_doy_ff  <= s2_doy_ff;
         s3_hour_ff <= s2_hour_ff;
      end
      if (ld4) begin
         s4_cmd_ff  <= s3_cmd_ff;
         s4_ok_ff   <= s3_ok_ff;
         s4_mid_ff  <= s3_mid_ff;
         s4_days_ff <= s4_days_in;
         s4_hour_ff <= s3_hour_ff;
      end
      if (ld5) begin
         s5_cmd_ff <= s4_cmd_ff;
         s5_ok_ff  <= s4_ok_ff;
         s5_mid_ff <= s4_mid_ff;
         s5_key_ff <= s5_key_in;
      end
      held_start_ff <= held_start_in;
      held_open_ff  <= held_open_in;
      held_high_ff  <= held_high_in;
      held_low_ff   <= held_low_in;
      held_close_ff <= held_close_in;
      // held bar goes out as it was before this beat's update
      if (p_go && p_emit) begin
         rsp_start_ff <= held_start_ff;
         rsp_open_ff  <= held_open_ff;
         rsp_high_ff  <= held_high_ff;
         rsp_low_ff   <= held_low_ff;
         rsp_close_ff <= held_close_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}},
                        MID_OUT_W'(rsp_close_ff),
                        MID_OUT_W'(rsp_low_ff),
                        MID_OUT_W'(rsp_high_ff),
                        MID_OUT_W'(rsp_open_ff),
                        rsp_start_ff};

   // ---------------------------------------------------------------- checks
   a_flush_closes_bar: assert property (@(posedge clock) disable iff (reset)
      (p_go && (s5_cmd_ff == CMD_FLUSH)) |=> !open_ff)
      else $error("bar still open after flush");

   a_bar_ordered: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (held_low_ff <= held_close_ff) && (held_close_ff <= held_high_ff) &&
                  (held_low_ff <= held_open_ff) && (held_open_ff <= held_high_ff))
      else $error("held bar prices out of order");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (p_go && p_emit) |-> (!rsp_vld_ff || rsp_tready))
      else $error("result loaded over a waiting beat");

   a_emit_needs_bar: assert property (@(posedge clock) disable iff (reset)
      (p_go && p_emit) |=> rsp_vld_ff && !$stable(rsp_vld_ff) || rsp_vld_ff)
      else $error("emitted bar not presented");

endmodule

// File: verif/ohlc_bar_checker.sv
// checker for the hourly bar builder: rebuilds bars from accepted ticks and compares rsp beats
`timescale 1ns / 1ps

module ohlc_bar_checker
   import ohlc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // year, month, day, hour, bid, ask
   input  logic                  req_tuser,   // cmd
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // bar_start, open, high, low, close
   output int                    mismatch_count,
   output int                    bars_pending,
   output int                    bars_compared
);

   typedef struct packed {
      start_type              start;
      logic [MID_OUT_W-1:0]   open;
      logic [MID_OUT_W-1:0]   high;
      logic [MID_OUT_W-1:0]   low;
      logic [MID_OUT_W-1:0]   close;
   } hour_bar_type;

   hour_bar_type bars_due[$];
   hour_bar_type live_bar;
   logic      bar_live = 1'b0;
   int        errors_seen = 0;
   int        bars_seen = 0;

   // epoch second of the hour start; days past month end simply run on
   function automatic start_type hour_start_sec(input year_type yr,
                                                input logic [MONTH_W-1:0] mo,
                                                input logic [DAY_W-1:0] dy,
                                                input logic [HOUR_W-1:0] hr);
      longint unsigned mo_l, y, era, yoe, mshift, doy, doe, days;
      mo_l   = 64'(mo);
      y      = 64'(yr) - ((mo_l <= 2) ? 64'd1 : 64'd0);
      era    = y / 400;
      yoe    = y - era * 400;
      mshift = (mo_l > 2) ? (mo_l - 3) : (mo_l + 9);
      doy    = (153 * mshift + 2) / 5 + 64'(dy) - 1;
      doe    = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days   = era * 146097 + doe - 719468;
      return start_type'(days * 86400 + 64'(hr) * 3600);
   endfunction

   task automatic check_field(input string name, input logic [START_W-1:0] want,
                              input logic [START_W-1:0] got);
      if (want !== got) begin
         errors_seen++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic take_bar(input logic [RSP_DATA_W-1:0] beat);
      hour_bar_type got, want;
      got.start = beat[0 +: START_W];
      got.open  = beat[START_W +: MID_OUT_W];
      got.high  = beat[START_W + MID_OUT_W +: MID_OUT_W];
      got.low   = beat[START_W + 2 * MID_OUT_W +: MID_OUT_W];
      got.close = beat[START_W + 3 * MID_OUT_W +: MID_OUT_W];
      if (bars_due.size() == 0) begin
         errors_seen++;
         $display("%0t: unexpected bar, expected none, got start %0d open %0d", $time,
                  got.start, got.open);
         return;
      end
      want = bars_due.pop_front();
      bars_seen++;
      check_field("bar_start", want.start, got.start);
      check_field("open_mid", START_W'(want.open), START_W'(got.open));
      check_field("high_mid", START_W'(want.high), START_W'(got.high));
      check_field("low_mid", START_W'(want.low), START_W'(got.low));
      check_field("close_mid", START_W'(want.close), START_W'(got.close));
   endtask

   task automatic take_beat(input logic cmd, input logic [REQ_DATA_W-1:0] beat);
      year_type             yr;
      logic [MONTH_W-1:0]   mo;
      logic [DAY_W-1:0]     dy;
      logic [HOUR_W-1:0]    hr;
      logic [PRICE_W-1:0]   bid, ask;
      logic [MID_OUT_W-1:0] mid;
      start_type            key;
      yr  = beat[YEAR_LSB +: YEAR_W];
      mo  = beat[MONTH_LSB +: MONTH_W];
      dy  = beat[DAY_LSB +: DAY_W];
      hr  = beat[HOUR_LSB +: HOUR_W];
      bid = beat[BID_LSB +: PRICE_W];
      ask = beat[ASK_LSB +: PRICE_W];
      if (cmd == CMD_FLUSH) begin
         if (bar_live) begin
            bars_due.push_back(live_bar);
            bar_live = 1'b0;
         end
         return;
      end
      if (yr < MIN_YEAR || mo < 1 || mo > MAX_MONTH || dy < 1 || dy > MAX_DAY ||
          hr > MAX_HOUR || bid == 0 || ask == 0)
         return;
      mid = MID_OUT_W'(bid) + MID_OUT_W'(ask);
      key = hour_start_sec(yr, mo, dy, hr);
      if (bar_live && key == live_bar.start) begin
         if (mid > live_bar.high) live_bar.high = mid;
         if (mid < live_bar.low) live_bar.low = mid;
         live_bar.close = mid;
         return;
      end
      // a tick of another hour closes the held bar
      if (bar_live)
         bars_due.push_back(live_bar);
      bar_live = 1'b1;
      live_bar = '{key, mid, mid, mid, mid};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bar_live = 1'b0;
         bars_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            take_bar(rsp_tdata);
         if (req_tvalid && req_tready)
            take_beat(req_tuser, req_tdata);
      end
      mismatch_count <= errors_seen;
      bars_pending   <= bars_due.size();
      bars_compared  <= bars_seen;
   end

endmodule

// File: verif/tb.sv
// testbench top: drives quote ticks and flushes into the hourly bar builder and gives the verdict
`timescale 1ns / 1ps

module tb;
   import ohlc_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int TICK_TARGET  = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // year, month, day, hour, bid, ask
   logic                  req_tuser = 1'b0;  // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // bar_start, open, high, low, close

   int mismatch_count, bars_pending, bars_compared;
   int cycle_count = 0;
   int stall_left = 0;
   logic calm = 1'b0;

   int beats_sent = 0, flushes_sent = 0, run_left = 0, pick;
   year_type           cur_year, yy;
   logic [MONTH_W-1:0] cur_month, mm;
   logic [DAY_W-1:0]   cur_day, dd;
   logic [HOUR_W-1:0]  cur_hour, hh;
   logic [PRICE_W-1:0] price_base, pb, pa;

   tick_to_hourly_ohlc_bars_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ohlc_bar_checker watch (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .bars_pending   (bars_pending),
      .bars_compared  (bars_compared)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[tick_to_hourly_ohlc_bars_top] ERROR");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none at all while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [PRICE_W-1:0] pick_price();
      int r;
      logic [PRICE_W-1:0] p;
      r = $urandom_range(0, 9);
      if (r < 7)
         p = price_base + $urandom_range(0, 400) - 200;
      else if (r < 9)
         p = $urandom;
      else
         p = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd1;
      if (p == 0) p = 1;
      return p;
   endfunction

   task automatic send_beat(input logic cmd, input year_type yr,
                            input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
                            input logic [HOUR_W-1:0] hr, input logic [PRICE_W-1:0] bid,
                            input logic [PRICE_W-1:0] ask);
      int gap;
      logic [REQ_DATA_W-1:0] beat;
      gap  = pick_gap();
      beat = '0;
      beat[YEAR_LSB +: YEAR_W]   = yr;
      beat[MONTH_LSB +: MONTH_W] = mo;
      beat[DAY_LSB +: DAY_W]     = dy;
      beat[HOUR_LSB +: HOUR_W]   = hr;
      beat[BID_LSB +: PRICE_W]   = bid;
      beat[ASK_LSB +: PRICE_W]   = ask;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if (cmd == CMD_FLUSH) flushes_sent++;
   endtask

   // step the market clock forward, now and then by 24 to 960 hours
   task automatic move_clock();
      int steps;
      steps = ($urandom_range(0, 19) == 0) ? $urandom_range(24, 24 * 40) : $urandom_range(1, 3);
      repeat (steps) begin
         cur_hour++;
         if (cur_hour > 23) begin
            cur_hour = 0;
            cur_day++;
            if (cur_day > 31 || (cur_day > 28 && $urandom_range(0, 3) != 0)) begin
               cur_day = 1;
               cur_month++;
               if (cur_month > 12) begin
                  cur_month = 1;
                  cur_year++;
                  if (cur_year > 9999) cur_year = 2000;
               end
            end
         end
      end
      price_base = $urandom_range(1000, 32'hFFFF_0000);
      run_left   = $urandom_range(1, 8);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty flush, price extremes, every drop reason, leap day, short months
      send_beat(CMD_FLUSH, 2000, 1, 1, 0, 5, 5);
      send_beat(CMD_TICK, 2000, 1, 1, 0, 1, 1);
      send_beat(CMD_TICK, 2000, 1, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(CMD_TICK, 2000, 1, 1, 0, 1, 2);
      send_beat(CMD_TICK, 1999, 1, 1, 0, 7, 7);
      send_beat(CMD_TICK, 2000, 0, 1, 0, 7, 7);
      send_beat(CMD_TICK, 2000, 13, 1, 0, 7, 7);
      send_beat(CMD_TICK, 2000, 99, 1, 0, 7, 7);
      send_beat(CMD_TICK, 2000, 1, 0, 0, 7, 7);
      send_beat(CMD_TICK, 2000, 1, 99, 0, 7, 7);
      send_beat(CMD_TICK, 2000, 1, 1, 24, 7, 7);
      send_beat(CMD_TICK, 2000, 1, 1, 99, 7, 7);
      send_beat(CMD_TICK, 2000, 1, 1, 0, 0, 7);
      send_beat(CMD_TICK, 2000, 1, 1, 0, 7, 0);
      send_beat(CMD_TICK, 2000, 2, 29, 23, 100, 300);
      send_beat(CMD_TICK, 2000, 3, 1, 0, 200, 200);
      send_beat(CMD_TICK, 2001, 2, 30, 5, 50, 60);
      send_beat(CMD_TICK, 2001, 3, 2, 5, 70, 80);
      send_beat(CMD_TICK, 2001, 4, 31, 12, 90, 90);
      send_beat(CMD_FLUSH, 14'h3FFF, 7'h7F, 7'h7F, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(CMD_FLUSH, 0, 0, 0, 0, 0, 0);
      send_beat(CMD_TICK, 9999, 12, 31, 23, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(CMD_TICK, 9999, 12, 31, 23, 1, 1);
      send_beat(CMD_TICK, 8192, 1, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(CMD_FLUSH, 0, 0, 0, 0, 0, 0);

      // random: runs of ticks per hour, with malformed ticks, flushes and date jumps mixed in
      cur_year   = 2010;
      cur_month  = 1;
      cur_day    = 1;
      cur_hour   = 0;
      price_base = 100_000;
      while (beats_sent < TICK_TARGET) begin
         if (beats_sent % 300 == 0)
            calm <= ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            if (run_left == 0) move_clock();
            run_left--;
            send_beat(CMD_TICK, cur_year, cur_month, cur_day, cur_hour,
                      pick_price(), pick_price());
         end else if (pick < 84) begin
            yy = cur_year;
            mm = cur_month;
            dd = cur_day;
            hh = cur_hour;
            pb = pick_price();
            pa = pick_price();
            case ($urandom_range(0, 5))
               0: yy = year_type'($urandom_range(0, 1999));
               1: mm = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(13, 99));
               2: dd = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom_range(32, 99));
               3: hh = 7'($urandom_range(24, 99));
               4: pb = 0;
               default: pa = 0;
            endcase
            send_beat(CMD_TICK, yy, mm, dd, hh, pb, pa);
         end else if (pick < 90) begin
            send_beat(CMD_TICK, year_type'($urandom_range(0, 9999)),
                      7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                      7'($urandom_range(0, 99)), $urandom, $urandom);
         end else if (pick < 95) begin
            send_beat(CMD_FLUSH, year_type'($urandom_range(0, 9999)),
                      7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                      7'($urandom_range(0, 99)), $urandom, $urandom);
         end else begin
            cur_year   = year_type'($urandom_range(2000, 9999));
            cur_month  = 7'($urandom_range(1, 12));
            cur_day    = 7'($urandom_range(1, 31));
            cur_hour   = 7'($urandom_range(0, 23));
            price_base = $urandom_range(1000, 32'hFFFF_0000);
            run_left   = $urandom_range(1, 8);
            send_beat(CMD_TICK, cur_year, cur_month, cur_day, cur_hour,
                      pick_price(), pick_price());
         end
      end
      // close out the last bar
      send_beat(CMD_FLUSH, 0, 0, 0, 0, 0, 0);
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (bars_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats, %0d of them flushes, with malformed ticks and date jumps",
               beats_sent, flushes_sent);
      $display("%0d bars compared field by field", bars_compared);
      if (mismatch_count == 0 && bars_pending == 0)
         $display("[tick_to_hourly_ohlc_bars_top] OK");
      else
         $display("[tick_to_hourly_ohlc_bars_top] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ohlc_pkg.sv
hw/rtl/tick_to_hourly_ohlc_bars_top.sv
verif/ohlc_bar_checker.sv
verif/tb.sv
